### rtl/core/sorted_timestep_schedule_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted timestep schedule unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMESTEP_SCHEDULE_UNIT_MACROS_SVH
`define SORTED_TIMESTEP_SCHEDULE_UNIT_MACROS_SVH

// same-cycle implication
`define STS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sts assertion failed: same-cycle implication");

// next-cycle implication
`define STS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sts assertion failed: next-cycle implication");

`endif

### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timestep schedule package
// Widths, operation codes, sequencer states and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    // field widths
    localparam int STEP_W    = 63;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    // operation codes carried in tuser
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_PLACE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    // comparator verdict: request step against stored entry
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

    // per-item status flags from the sequencer
    typedef struct packed {
        logic hit;
        logic overflow;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/sts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/sts_cmp.sv
// ----------------------------------------------------------------------------
// Shared timestep comparator
// Compares the request step with one stored entry: equal and less-than.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_cmp (
    input  wire logic [sts_pkg::STEP_W-1:0] step,
    input  wire logic [sts_pkg::STEP_W-1:0] entry,
    output sts_pkg::cmp_res_t               res
);

    import sts_pkg::*;

    // one wide compare, reused for search, discard and insert decisions
    always_comb
    begin
        res.eq = (step == entry);
        res.lt = (step < entry);
    end

endmodule

`default_nettype wire

### rtl/core/sts_seq.sv
// ----------------------------------------------------------------------------
// Schedule sequencer
// Walks the sorted store one entry at a time through the shared comparator,
// then, for an add, shifts entries up to open an insert slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_seq #(
    parameter int DEPTH = sts_pkg::DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // item start
    output logic                              in_ready,
    input  wire logic                         start,
    input  wire logic [1:0]                   start_kind,
    input  wire logic [sts_pkg::STEP_W-1:0]   start_step,
    // shared comparator
    output logic      [sts_pkg::STEP_W-1:0]   cmp_step,
    input  wire sts_pkg::cmp_res_t            cmp_res,
    // store
    output logic                              rd_en,
    output logic      [$clog2(DEPTH)-1:0]     rd_addr,
    input  wire logic [sts_pkg::STEP_W-1:0]   rd_data,
    output logic                              wr_en,
    output logic      [$clog2(DEPTH)-1:0]     wr_addr,
    output logic      [sts_pkg::STEP_W-1:0]   wr_data,
    // result
    output logic                              done_valid,
    input  wire logic                         done_ack,
    output sts_pkg::res_t                     done_res,
    output logic      [$clog2(DEPTH+1)-1:0]   done_fill
);

    import sts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     fill_reg, fill_next;
    res_t              res_reg, res_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = AW'(idx_reg - 1'b1);
        wr_en      = 1'b0;
        wr_addr    = pos_reg[AW-1:0];
        wr_data    = step_reg;
        done_valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next         = start_kind;
                    step_next         = start_step;
                    idx_next          = fill_reg;
                    res_next.hit      = 1'b0;
                    res_next.overflow = 1'b0;
                    case (start_kind)
                        KIND_ADD:   state_next = ST_SEARCH_RD;
                        KIND_MATCH: state_next = ST_SEARCH_RD;
                        KIND_CLEAR:
                        begin
                            fill_next  = '0;
                            state_next = ST_DONE;
                        end
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            // fetch the next entry up from the smallest one
            ST_SEARCH_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = (kind_reg == KIND_ADD) ? ST_PLACE : ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SEARCH_CMP;
                end
            end

            // add stops at equal or at a larger entry; match drops smaller ones
            ST_SEARCH_CMP:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    if (cmp_res.eq)
                    begin
                        res_next.hit = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (cmp_res.lt)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_SEARCH_RD;
                    end
                end
                else
                begin
                    if (!cmp_res.eq && !cmp_res.lt)
                    begin
                        fill_next  = fill_reg - 1'b1;
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_SEARCH_RD;
                    end
                    else
                    begin
                        res_next.hit = cmp_res.eq;
                        state_next   = ST_DONE;
                    end
                end
            end

            // full store drops a new value
            ST_PLACE:
            begin
                if (fill_reg >= CW'(DEPTH))
                begin
                    res_next.overflow = 1'b1;
                    state_next        = ST_DONE;
                end
                else
                begin
                    pos_next   = fill_reg;
                    state_next = ST_SHIFT_RD;
                end
            end

            // shift entries up one slot until the insert slot is reached
            ST_SHIFT_RD:
            begin
                if (pos_reg == idx_reg)
                begin
                    wr_en      = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(pos_reg - 1'b1);
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                pos_next   = pos_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end

            ST_DONE:
            begin
                done_valid = 1'b1;
                if (done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cmp_step  = step_reg;
    assign done_res  = res_reg;
    assign done_fill = fill_reg;

endmodule

`default_nettype wire

### rtl/core/sorted_timestep_schedule_unit.sv
// ----------------------------------------------------------------------------
// Sorted timestep schedule unit
// Bounded sorted set of pending timesteps: add, match with discard, clear.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload
//  s_axis    in         tuser: kind; tdata: timestep
//  m_axis    out        tdata: hit, entry_count, overflow
//
//  clear and unused kinds go from accept straight to the done state
//  match reads and compares entries one at a time, discarding each smaller one
//  add reads entries one at a time to find its slot, then shifts each smaller entry up;
//  the pace is set by the single store read port and one comparator
//  rst_n clears the fill count and the sequencer; store contents stay undefined
//  a new item is taken while a finished result waits in the output register
//
`default_nettype none

module sorted_timestep_schedule_unit #(
    parameter int DEPTH = sts_pkg::DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [62:0] timestep
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] hit, [5:1] entry_count, [6] overflow
);

    import sts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              start;
    logic [STEP_W-1:0] cmp_step;
    cmp_res_t          cmp_res;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [STEP_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [STEP_W-1:0] wr_data;
    logic              done_valid;
    logic              done_ack;
    res_t              done_res;
    logic [CW-1:0]     done_fill;

    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg;
    logic               out_ovf_reg;
    logic [COUNT_W-1:0] out_count_reg;

    assign start = s_axis_tvalid && s_axis_tready;

    // sequencer
    sts_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ready   (s_axis_tready),
        .start      (start),
        .start_kind (s_axis_tuser),
        .start_step (s_axis_tdata[STEP_W-1:0]),
        .cmp_step   (cmp_step),
        .cmp_res    (cmp_res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .done_valid (done_valid),
        .done_ack   (done_ack),
        .done_res   (done_res),
        .done_fill  (done_fill)
    );

    // shared comparator
    sts_cmp u_cmp (
        .step  (cmp_step),
        .entry (rd_data),
        .res   (cmp_res)
    );

    // timestep store
    sts_ram #(
        .WIDTH (STEP_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register, loaded when empty or being drained
    assign done_ack = done_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ack)
        begin
            out_hit_reg   <= done_res.hit;
            out_ovf_reg   <= done_res.overflow;
            out_count_reg <= COUNT_W'(done_fill);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_ovf_reg, out_count_reg, out_hit_reg};

endmodule

`default_nettype wire

### rtl/core/sts_checker.sv
// ----------------------------------------------------------------------------
// Sorted timestep schedule checker
// Port-level assertions on the schedule unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_timestep_schedule_unit_macros.svh"

module sts_checker #(
    parameter int DEPTH = sts_pkg::DEPTH_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [63:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    import sts_pkg::*;

    // a stalled result holds
    `STS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one item at a time: input closes after each accept
    `STS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // dropped add never reports a hit
    `STS_ASSERT_IMP(a_ovf_no_hit, m_axis_tvalid, !(m_axis_tdata[6] && m_axis_tdata[0]))

    // dropped add only with a full store
    `STS_ASSERT_IMP(a_ovf_full, m_axis_tvalid && m_axis_tdata[6], (DEPTH > 31) || (m_axis_tdata[5:1] == 5'(DEPTH)))

    // count never exceeds the store depth
    `STS_ASSERT_IMP(a_count_bound, m_axis_tvalid, (DEPTH > 31) || (m_axis_tdata[5:1] <= 5'(DEPTH)))

endmodule

bind sorted_timestep_schedule_unit sts_checker #(.DEPTH(DEPTH)) u_sts_checker (.*);

`default_nettype wire

### dv/sts_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timestep schedule scoreboard
// Shadow copy of the pending timestep store and the queue of outcomes it
// predicts, checked in order against each result item from the unit.
// ----------------------------------------------------------------------------

package sts_scoreboard_pkg;

    import sts_pkg::*;

    // kind code that the unit ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one result item as it appears on m_axis_tdata
    typedef struct packed {
        logic               overflow;
        logic [COUNT_W-1:0] entry_count;
        logic               hit;
    } outcome_t;

    class schedule_scoreboard;

        // shadow store, largest timestep at index 0, smallest at shadow_fill-1
        logic [STEP_W-1:0] shadow_steps[DEPTH_DEF];
        int                shadow_fill;
        outcome_t          expected_outcomes[$];

        int mismatches;
        int items_noted;
        int outcomes_checked;
        int hits_seen;
        int drops_seen;
        int times_full;

        function void reset_shadow();
            shadow_fill = 0;
            expected_outcomes.delete();
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // apply one item to the shadow store and return what the unit must answer
        function outcome_t predict_schedule(logic [1:0] kind, logic [STEP_W-1:0] step);
            outcome_t res;
            int       k;
            int       j;
            bit       found;
            bit       stop;
            res   = '0;
            found = 1'b0;
            stop  = 1'b0;
            case (kind)
                KIND_ADD:
                begin
                    // walk up from the smallest entry to the insert position
                    k = shadow_fill;
                    while (k > 0 && !stop)
                    begin
                        if (step == shadow_steps[k-1])
                        begin
                            found = 1'b1;
                            stop  = 1'b1;
                        end
                        else if (step < shadow_steps[k-1])
                            stop = 1'b1;
                        else
                            k--;
                    end
                    if (found)
                        res.hit = 1'b1;
                    else if (shadow_fill >= DEPTH_DEF)
                        res.overflow = 1'b1;
                    else
                    begin
                        for (j = shadow_fill; j > k; j--)
                            shadow_steps[j] = shadow_steps[j-1];
                        shadow_steps[k] = step;
                        shadow_fill++;
                        if (shadow_fill == DEPTH_DEF)
                            times_full++;
                    end
                end
                KIND_MATCH:
                begin
                    // drop everything older than the requested step
                    while (shadow_fill > 0 && shadow_steps[shadow_fill-1] < step)
                        shadow_fill--;
                    if (shadow_fill > 0 && shadow_steps[shadow_fill-1] == step)
                        res.hit = 1'b1;
                end
                KIND_CLEAR:
                    shadow_fill = 0;
                default:
                    ;
            endcase
            res.entry_count = shadow_fill[COUNT_W-1:0];
            return res;
        endfunction

        function void note_item(logic [1:0] kind, logic [STEP_W-1:0] step);
            items_noted++;
            expected_outcomes.push_back(predict_schedule(kind, step));
        endfunction

        task check_outcome(logic [7:0] tdata);
            outcome_t got;
            outcome_t want;
            got = tdata[6:0];
            outcomes_checked++;
            if (tdata[7] !== 1'b0)
                report_mismatch($sformatf("padding bit set in result tdata %h", tdata));
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", tdata));
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit %b, expected %b",
                                              outcomes_checked, got.hit, want.hit));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                              outcomes_checked, got.entry_count,
                                              want.entry_count));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                              outcomes_checked, got.overflow,
                                              want.overflow));
            end
            if (got.hit === 1'b1)
                hits_seen++;
            if (got.overflow === 1'b1)
                drops_seen++;
        endtask

    endclass

endpackage

### dv/sorted_timestep_schedule_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timestep schedule unit testbench
// Drives add, match, clear and ignored items into the unit with random gaps
// on both streams and one long output stall, and checks every result item
// against a shadow copy of the sorted store.
// ----------------------------------------------------------------------------

module sorted_timestep_schedule_unit_tb;

    import sts_pkg::*;
    import sts_scoreboard_pkg::*;

    localparam int  RANDOM_ITEMS = 1250;
    localparam int  HOLD_AT      = 300;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 4 * DEPTH_DEF + 16;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [62:0] timestep
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] hit, [5:1] entry_count, [6] overflow

    schedule_scoreboard sched_sb;
    bit                 sender_burst = 1'b0;
    int                 cycle_count  = 0;
    int                 results_seen = 0;

    sorted_timestep_schedule_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [STEP_W-1:0] any_step();
        return STEP_W'({$urandom, $urandom});
    endfunction

    // offer one item after a random gap, return once it is accepted
    task automatic send_item(logic [1:0] kind, logic [STEP_W-1:0] step);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, step};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sched_sb.note_item(kind, step);
        @(negedge clk);
    endtask

    // result side: random stalls, one long hold-off to back the unit up
    initial
    begin : result_sink
        int  gap;
        bit  sink_burst;
        sink_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen % 50 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            if (results_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = sink_burst ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sched_sb.check_outcome(m_axis_tdata);
            results_seen++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [STEP_W-1:0] base;
        logic [STEP_W-1:0] step;
        int                sent;
        int                seg_len;
        int                add_pct;
        int                r;
        int                i;

        sched_sb = new();
        sched_sb.reset_shadow();

        // hold reset low, then release it
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty store, duplicates, extremes, discard, ignored kind, clear
        send_item(KIND_MATCH, 63'd7);
        send_item(KIND_ADD, '0);
        send_item(KIND_ADD, '0);
        send_item(KIND_ADD, STEP_MAX);
        send_item(KIND_ADD, 63'd5);
        send_item(KIND_MATCH, 63'd3);
        send_item(KIND_MATCH, 63'd5);
        send_item(KIND_UNUSED, STEP_MAX);
        send_item(KIND_CLEAR, STEP_MAX);

        // directed: fill to capacity, then a dropped add, a duplicate on full and a match
        for (i = 0; i < DEPTH_DEF; i++)
            send_item(KIND_ADD, (i % 2 == 0) ? STEP_MAX - STEP_W'(i) : STEP_W'(i));
        send_item(KIND_ADD, 63'd1000);
        send_item(KIND_ADD, STEP_MAX);
        send_item(KIND_MATCH, STEP_MAX);

        // random: segments of well-formed schedule traffic around a moving now
        sent = 0;
        base = 63'd100;
        while (sent < RANDOM_ITEMS)
        begin
            seg_len      = $urandom_range(20, 80);
            add_pct      = $urandom_range(30, 90);
            sender_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: base = any_step();
                1: base = STEP_MAX - STEP_W'($urandom_range(0, 60));
                2: base = STEP_W'($urandom_range(0, 20));
                default: ;
            endcase
            for (i = 0; i < seg_len && sent < RANDOM_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    send_item(KIND_CLEAR, any_step());
                else if (r < 4)
                    send_item(KIND_UNUSED, any_step());
                else if (r < 7)
                    send_item(($urandom_range(0, 1) == 0) ? KIND_ADD : KIND_MATCH,
                              any_step());
                else if ($urandom_range(0, 99) < add_pct)
                    send_item(KIND_ADD, base + STEP_W'($urandom_range(0, 48)));
                else
                begin
                    step = base + STEP_W'($urandom_range(0, 12));
                    send_item(KIND_MATCH, step);
                    base = step;
                end
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then let the unit settle
        while (sched_sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sched_sb.outstanding() != 0)
            sched_sb.report_mismatch($sformatf("%0d results never arrived",
                                               sched_sb.outstanding()));

        $display("covered %0d items and %0d results: %0d hits, %0d dropped adds",
                 sched_sb.items_noted, sched_sb.outcomes_checked,
                 sched_sb.hits_seen, sched_sb.drops_seen);
        $display("store filled to capacity %0d times, %0d mismatches",
                 sched_sb.times_full, sched_sb.mismatches);
        if (sched_sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sts_pkg.sv
rtl/core/sts_ram.sv
rtl/core/sts_cmp.sv
rtl/core/sts_seq.sv
rtl/core/sorted_timestep_schedule_unit.sv
rtl/core/sts_checker.sv
dv/sts_scoreboard_pkg.sv
dv/sorted_timestep_schedule_unit_tb.sv
